### rtl/core/trie_insert_search_counter_top_macros.svh
// Assertion macros for the trie insert/search engine.
// Included by the RTL files that carry concurrent checks; expects clk and rst_n in scope.
`ifndef TRIE_INSERT_SEARCH_COUNTER_TOP_MACROS_SVH
`define TRIE_INSERT_SEARCH_COUNTER_TOP_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, disabled while reset is asserted.
`define TISC_ASSERT_IMP(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("tisc: same-cycle check failed");
// Next-cycle implication, disabled while reset is asserted.
`define TISC_ASSERT_NXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("tisc: next-cycle check failed");
`else
`define TISC_ASSERT_IMP(label, ante, cons)
`define TISC_ASSERT_NXT(label, ante, cons)
`endif
`endif

### rtl/core/tisc_pkg.sv
// Shared types and constants for the trie insert/search engine.
// No dependencies; imported by the interfaces, the walk sequencer and the top level.
`default_nettype none

package tisc_pkg;

    // Field widths of the item channels.
    localparam int KIND_W   = 2;
    localparam int LETTER_W = 6;
    localparam int COUNT_W  = 16;

    // Item kinds.
    localparam logic [KIND_W-1:0] KIND_INSERT = 2'd0;
    localparam logic [KIND_W-1:0] KIND_SEARCH = 2'd1;
    localparam logic [KIND_W-1:0] KIND_CLEAR  = 2'd2;
    localparam logic [KIND_W-1:0] KIND_UNUSED = 2'd3;

    // End counts saturate here.
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    // Walk sequencer states.
    typedef enum logic [1:0] {
        S_IDLE,
        S_LINK,
        S_NODE
    } tisc_state_t;

    // One result item handed from the walk sequencer to the output register.
    typedef struct packed {
        logic               valid;
        logic [COUNT_W-1:0] word_count;
        logic               table_full;
    } tisc_result_t;

endpackage

`default_nettype wire

### rtl/core/tisc_in_if.sv
// Input item channel: valid/ready handshake with one letter item as payload.
// Depends on tisc_pkg for the field widths.
`default_nettype none

interface tisc_in_if;
    import tisc_pkg::*;

    logic                valid;
    logic                ready;
    logic [KIND_W-1:0]   kind;
    logic [LETTER_W-1:0] letter_code;
    logic                last_letter;

    modport source (output valid, output kind, output letter_code, output last_letter,
                    input ready);
    modport sink   (input valid, input kind, input letter_code, input last_letter,
                    output ready);
endinterface

`default_nettype wire

### rtl/core/tisc_out_if.sv
// Result item channel: valid/ready handshake with a word count and a full flag.
// Depends on tisc_pkg for the field widths.
`default_nettype none

interface tisc_out_if;
    import tisc_pkg::*;

    logic               valid;
    logic               ready;
    logic [COUNT_W-1:0] word_count;
    logic               table_full;

    modport source (output valid, output word_count, output table_full, input ready);
    modport sink   (input valid, input word_count, input table_full, output ready);
endinterface

`default_nettype wire

### rtl/core/tisc_ram.sv
// Simple dual-port synchronous RAM: one write port, one read port, registered read data.
// No dependencies; instantiated twice by the top level (link store and node store).
`default_nettype none

module tisc_ram #(
    parameter int DEPTH = 16384,
    parameter int WIDTH = 16,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  wire logic              clk,
    input  wire logic              we,
    input  wire logic [ADDR_W-1:0] waddr,
    input  wire logic [WIDTH-1:0]  wdata,
    input  wire logic              re,
    input  wire logic [ADDR_W-1:0] raddr,
    output logic      [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    // Write port.
    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
    end

    // Read port; data holds until the next read.
    always_ff @(posedge clk)
    begin
        if (re)
        begin
            rdata_reg <= mem_reg[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

`default_nettype wire

### rtl/core/tisc_walk.sv
// Walk sequencer of the trie engine: follows child links, allocates nodes, updates counts.
// Depends on tisc_pkg, tisc_in_if and the assertion macro header; drives both RAMs.
`default_nettype none
`include "trie_insert_search_counter_top_macros.svh"

module tisc_walk #(
    parameter int NODE_COUNT    = 16384,
    parameter int ALPHABET_SIZE = 52,
    localparam int NW  = $clog2(NODE_COUNT),
    localparam int AW  = $clog2(NODE_COUNT * ALPHABET_SIZE),
    localparam int NMW = AW + tisc_pkg::COUNT_W
) (
    input  wire logic                  clk,
    input  wire logic                  rst_n,
    tisc_in_if.sink                    req,
    output logic                       link_re,
    output logic [AW-1:0]              link_raddr,
    input  wire logic [NW-1:0]         link_rdata,
    output logic                       link_we,
    output logic [AW-1:0]              link_waddr,
    output logic [NW-1:0]              link_wdata,
    output logic                       node_re,
    output logic [NW-1:0]              node_raddr,
    input  wire logic [NMW-1:0]        node_rdata,
    output logic                       node_we,
    output logic [NW-1:0]              node_waddr,
    output logic [NMW-1:0]             node_wdata,
    output tisc_pkg::tisc_result_t     res,
    input  wire logic                  res_ready
);
    import tisc_pkg::*;

    localparam int LW = $clog2(ALPHABET_SIZE);
    localparam int FW = $clog2(NODE_COUNT + 1);
    localparam logic [FW-1:0] FREE_LIMIT = FW'(NODE_COUNT);
    localparam logic [FW-1:0] FREE_FIRST = FW'(1);
    localparam logic [AW-1:0] ALPHA_AW   = AW'(ALPHABET_SIZE);
    localparam logic [LW-1:0] LETTER_TOP = LW'(ALPHABET_SIZE - 1);

    // Control state.
    tisc_state_t        state_reg, state_next;
    logic [NW-1:0]      cursor_reg, cursor_next;
    logic [FW-1:0]      next_free_reg, next_free_next;
    logic               missed_reg, missed_next;
    logic               overflow_reg, overflow_next;

    // Item held while it is walked.
    logic [KIND_W-1:0]  kind_reg, kind_next;
    logic               last_reg, last_next;
    logic [AW-1:0]      slot_reg, slot_next;
    logic [NW-1:0]      child_reg, child_next;

    // Walk decision terms.
    logic [31:0]        code_ext;
    logic [LW-1:0]      letter_sat;
    logic [AW-1:0]      slot_calc;
    logic [AW-1:0]      node_parent;
    logic [COUNT_W-1:0] node_count;
    logic               link_ok;
    logic               node_go;
    logic               miss_now;
    logic               ovf_now;
    logic [COUNT_W-1:0] cnt_old;
    logic [COUNT_W-1:0] cnt_new;
    logic               letter_take;

    // Letter saturation and the link slot of the cursor.
    assign code_ext   = 32'(req.letter_code);
    assign letter_sat = (code_ext >= 32'(ALPHABET_SIZE)) ? LETTER_TOP : LW'(code_ext);
    assign slot_calc  = AW'(cursor_reg) * ALPHA_AW + AW'(letter_sat);

    // A stored link counts only if its child was allocated since the last clear
    // and that child names this very slot as its parent.
    assign node_parent = node_rdata[NMW-1:COUNT_W];
    assign node_count  = node_rdata[COUNT_W-1:0];
    assign link_ok     = (child_reg != '0) && (FW'(child_reg) < next_free_reg)
                         && (node_parent == slot_reg);

    assign req.ready   = (state_reg == S_IDLE);
    assign letter_take = req.valid && req.ready
                         && ((req.kind == KIND_INSERT) || (req.kind == KIND_SEARCH));
    assign node_go     = !last_reg || res_ready;

    // Next state.
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (letter_take)
                begin
                    state_next = S_LINK;
                end
            end
            S_LINK:
            begin
                state_next = S_NODE;
            end
            S_NODE:
            begin
                if (node_go)
                begin
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Datapath, memory controls and result.
    always_comb
    begin
        cursor_next    = cursor_reg;
        next_free_next = next_free_reg;
        missed_next    = missed_reg;
        overflow_next  = overflow_reg;
        kind_next      = kind_reg;
        last_next      = last_reg;
        slot_next      = slot_reg;
        child_next     = child_reg;
        link_re        = 1'b0;
        link_raddr     = slot_calc;
        link_we        = 1'b0;
        link_waddr     = slot_reg;
        link_wdata     = NW'(next_free_reg);
        node_re        = 1'b0;
        node_raddr     = link_rdata;
        node_we        = 1'b0;
        node_waddr     = NW'(next_free_reg);
        node_wdata     = {slot_reg, {COUNT_W{1'b0}}};
        miss_now       = missed_reg;
        ovf_now        = overflow_reg;
        cnt_old        = '0;
        cnt_new        = '0;
        res            = '0;
        case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    case (req.kind)
                        KIND_INSERT, KIND_SEARCH:
                        begin
                            link_re   = 1'b1;
                            slot_next = slot_calc;
                            kind_next = req.kind;
                            last_next = req.last_letter;
                        end
                        KIND_CLEAR:
                        begin
                            next_free_next = FREE_FIRST;
                            cursor_next    = '0;
                            missed_next    = 1'b0;
                            overflow_next  = 1'b0;
                        end
                        default:
                        begin
                            // Unused kind: dropped without effect.
                        end
                    endcase
                end
            end
            S_LINK:
            begin
                node_re    = 1'b1;
                child_next = link_rdata;
            end
            S_NODE:
            begin
                if (node_go)
                begin
                    // Walk one link unless the word already broke.
                    if (!missed_reg && !overflow_reg)
                    begin
                        if (link_ok)
                        begin
                            cursor_next = child_reg;
                            cnt_old     = node_count;
                        end
                        else if (kind_reg == KIND_INSERT)
                        begin
                            if (next_free_reg < FREE_LIMIT)
                            begin
                                link_we        = 1'b1;
                                node_we        = 1'b1;
                                cursor_next    = NW'(next_free_reg);
                                next_free_next = next_free_reg + FREE_FIRST;
                            end
                            else
                            begin
                                ovf_now = 1'b1;
                            end
                        end
                        else
                        begin
                            miss_now = 1'b1;
                        end
                    end
                    missed_next   = miss_now;
                    overflow_next = ovf_now;
                    cnt_new = ((kind_reg == KIND_INSERT) && (cnt_old != COUNT_MAX))
                              ? cnt_old + 16'd1 : cnt_old;
                    // A fresh node starts at zero, or at one when the word ends on it.
                    if (last_reg)
                    begin
                        node_wdata = {slot_reg, cnt_new};
                    end
                    // End of word: answer, bump the count on an insert, return to the root.
                    if (last_reg)
                    begin
                        res.valid      = 1'b1;
                        res.table_full = ovf_now;
                        res.word_count = (miss_now || ovf_now) ? '0 : cnt_new;
                        if (link_ok && !missed_reg && !overflow_reg
                            && (kind_reg == KIND_INSERT))
                        begin
                            node_we    = 1'b1;
                            node_waddr = child_reg;
                        end
                        cursor_next   = '0;
                        missed_next   = 1'b0;
                        overflow_next = 1'b0;
                    end
                end
            end
            default:
            begin
            end
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            cursor_reg    <= '0;
            next_free_reg <= FREE_FIRST;
            missed_reg    <= 1'b0;
            overflow_reg  <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cursor_reg    <= cursor_next;
            next_free_reg <= next_free_next;
            missed_reg    <= missed_next;
            overflow_reg  <= overflow_next;
        end
    end

    // Item payload registers.
    always_ff @(posedge clk)
    begin
        kind_reg  <= kind_next;
        last_reg  <= last_next;
        slot_reg  <= slot_next;
        child_reg <= child_next;
    end

    // Checks on the walk sequencer.
    `TISC_ASSERT_IMP(a_free_bounds, 1'b1, (next_free_reg >= FREE_FIRST) && (next_free_reg <= FREE_LIMIT))
    `TISC_ASSERT_IMP(a_cursor_alloc, 1'b1, FW'(cursor_reg) < next_free_reg)
    `TISC_ASSERT_IMP(a_link_with_node, link_we, node_we && (node_waddr == link_wdata))
    `TISC_ASSERT_IMP(a_result_at_end, res.valid, (state_reg == S_NODE) && last_reg && res_ready)
    `TISC_ASSERT_NXT(a_letter_walks, letter_take, state_reg == S_LINK)

endmodule

`default_nettype wire

### rtl/core/trie_insert_search_counter_top.sv
// Top level of the trie insert/search engine: walk sequencer, link and node RAMs,
// output register. Depends on tisc_pkg, tisc_in_if, tisc_out_if, tisc_ram, tisc_walk.
//
//  Channel  Dir  Payload                              Accepted when
//  req      in   kind, letter_code, last_letter       req.valid && req.ready
//  rsp      out  word_count, table_full               rsp.valid && rsp.ready
//
// A letter item goes through accept with the link RAM read, the node RAM read
// addressed by the returned link, then the decision with write-back, where a final
// letter can stall. The two dependent RAM reads set these steps. Clear and unused
// items stay in the accept state. Reset and clear take effect at once: links are
// checked against the node store, so neither RAM needs a clearing pass.
// A final letter waits in the decision state while the output register holds an
// untaken result; the block still takes the next item while a result waits.
`default_nettype none

module trie_insert_search_counter_top #(
    parameter int NODE_COUNT    = 16384,
    parameter int ALPHABET_SIZE = 52
) (
    input  wire logic  clk,
    input  wire logic  rst_n,
    tisc_in_if.sink    req,
    tisc_out_if.source rsp
);
    import tisc_pkg::*;

    localparam int NW    = $clog2(NODE_COUNT);
    localparam int AW    = $clog2(NODE_COUNT * ALPHABET_SIZE);
    localparam int NMW   = AW + COUNT_W;
    localparam int SLOTS = NODE_COUNT * ALPHABET_SIZE;

    logic               link_re;
    logic [AW-1:0]      link_raddr;
    logic [NW-1:0]      link_rdata;
    logic               link_we;
    logic [AW-1:0]      link_waddr;
    logic [NW-1:0]      link_wdata;
    logic               node_re;
    logic [NW-1:0]      node_raddr;
    logic [NMW-1:0]     node_rdata;
    logic               node_we;
    logic [NW-1:0]      node_waddr;
    logic [NMW-1:0]     node_wdata;
    tisc_result_t       res;
    logic               res_ready;

    logic               out_valid_reg;
    logic [COUNT_W-1:0] out_count_reg;
    logic               out_full_reg;

    // Walk sequencer.
    tisc_walk #(
        .NODE_COUNT    (NODE_COUNT),
        .ALPHABET_SIZE (ALPHABET_SIZE)
    ) u_walk (
        .clk        (clk),
        .rst_n      (rst_n),
        .req        (req),
        .link_re    (link_re),
        .link_raddr (link_raddr),
        .link_rdata (link_rdata),
        .link_we    (link_we),
        .link_waddr (link_waddr),
        .link_wdata (link_wdata),
        .node_re    (node_re),
        .node_raddr (node_raddr),
        .node_rdata (node_rdata),
        .node_we    (node_we),
        .node_waddr (node_waddr),
        .node_wdata (node_wdata),
        .res        (res),
        .res_ready  (res_ready)
    );

    // Child link store, one entry per node and letter.
    tisc_ram #(
        .DEPTH (SLOTS),
        .WIDTH (NW)
    ) u_link_ram (
        .clk   (clk),
        .we    (link_we),
        .waddr (link_waddr),
        .wdata (link_wdata),
        .re    (link_re),
        .raddr (link_raddr),
        .rdata (link_rdata)
    );

    // Node store: parent slot and end count per node.
    tisc_ram #(
        .DEPTH (NODE_COUNT),
        .WIDTH (NMW)
    ) u_node_ram (
        .clk   (clk),
        .we    (node_we),
        .waddr (node_waddr),
        .wdata (node_wdata),
        .re    (node_re),
        .raddr (node_raddr),
        .rdata (node_rdata)
    );

    // Output register: takes a new result when empty or being drained.
    assign res_ready = !out_valid_reg || rsp.ready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (res.valid)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (rsp.ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (res.valid)
        begin
            out_count_reg <= res.word_count;
            out_full_reg  <= res.table_full;
        end
    end

    assign rsp.valid      = out_valid_reg;
    assign rsp.word_count = out_count_reg;
    assign rsp.table_full = out_full_reg;

endmodule

`default_nettype wire

### bench/tb.sv
// Self-checking testbench for the trie insert/search engine: directed words, random words
// and a back-to-back repeat pass, checked against a local trie model or typed expectations.
// Depends on tisc_pkg, tisc_in_if, tisc_out_if and trie_insert_search_counter_top.
`default_nettype none

module tb;
    timeunit 1ns;
    timeprecision 1ps;

    import tisc_pkg::*;

    localparam int TRIE_NODES = 16384;
    localparam int LETTERS    = 52;
    localparam int NODE_W     = $clog2(TRIE_NODES);
    localparam int IDLE_LIMIT = 4000;

    // One expected result item.
    typedef struct packed {
        logic [COUNT_W-1:0] count;
        logic               full;
    } word_result_t;

    // One row of the directed table; count and full are used only when typed is set.
    typedef struct {
        logic [KIND_W-1:0]   kind;
        logic [LETTER_W-1:0] code;
        logic                last;
        bit                  typed;
        logic [COUNT_W-1:0]  count;
        logic                full;
    } stim_row_t;

    // How the letters of a random word pick their kind.
    typedef enum int {
        WORD_INSERT,
        WORD_SEARCH,
        WORD_MIXED
    } word_style_t;

    logic clk;
    logic rst_n;

    tisc_in_if  req_ch ();
    tisc_out_if rsp_ch ();

    trie_insert_search_counter_top #(
        .NODE_COUNT    (TRIE_NODES),
        .ALPHABET_SIZE (LETTERS)
    ) DUT (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch)
    );

    // Local trie: child links, end counts and the walk state of the word in progress.
    logic [NODE_W-1:0]  trie_child [TRIE_NODES*LETTERS];
    logic [COUNT_W-1:0] trie_count [TRIE_NODES];
    int unsigned        walk_node;
    int unsigned        free_node;
    bit                 walk_missed;
    bit                 walk_overflow;

    word_result_t expected_words [$];
    int           fail_count;
    int           items_sent;
    int           burst_left;
    bit           no_gaps;
    logic [LETTER_W-1:0] letter_pool [4];

    // Fixed expectation travelling alongside the item on the input channel.
    bit                 typed_now;
    logic [COUNT_W-1:0] typed_count;
    logic               typed_full;

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    function automatic void wipe_trie();
        foreach (trie_child[i])
        begin
            trie_child[i] = '0;
        end
        foreach (trie_count[i])
        begin
            trie_count[i] = '0;
        end
        walk_node     = 0;
        free_node     = 1;
        walk_missed   = 1'b0;
        walk_overflow = 1'b0;
    endfunction

    // Applies one accepted item to the local trie; returns 1 when it ends a word.
    function automatic bit walk_letter(input logic [KIND_W-1:0] kind,
                                       input logic [LETTER_W-1:0] code,
                                       input logic last,
                                       output word_result_t res);
        int unsigned        letter;
        int unsigned        slot;
        logic [COUNT_W-1:0] cnt;

        res = '0;
        if (kind == KIND_CLEAR)
        begin
            wipe_trie();
            return 1'b0;
        end
        if (kind == KIND_UNUSED)
        begin
            return 1'b0;
        end

        // Codes past the alphabet fold onto its last letter.
        letter = (code >= LETTERS) ? LETTERS - 1 : code;

        // A broken word stops walking until its final letter.
        if (!walk_missed && !walk_overflow)
        begin
            slot = walk_node * LETTERS + letter;
            if (trie_child[slot] != '0)
            begin
                walk_node = trie_child[slot];
            end
            else if (kind == KIND_INSERT)
            begin
                if (free_node < TRIE_NODES)
                begin
                    trie_child[slot] = NODE_W'(free_node);
                    walk_node        = free_node;
                    free_node++;
                end
                else
                begin
                    walk_overflow = 1'b1;
                end
            end
            else
            begin
                walk_missed = 1'b1;
            end
        end

        if (!last)
        begin
            return 1'b0;
        end

        // The final letter's kind decides between increment and plain read.
        cnt = '0;
        if (!walk_missed && !walk_overflow)
        begin
            cnt = trie_count[walk_node];
            if (kind == KIND_INSERT && cnt != COUNT_MAX)
            begin
                cnt                   = cnt + 1'b1;
                trie_count[walk_node] = cnt;
            end
        end
        res.count     = cnt;
        res.full      = walk_overflow;
        walk_node     = 0;
        walk_missed   = 1'b0;
        walk_overflow = 1'b0;
        return 1'b1;
    endfunction

    // Predicts on every accepted item and checks every accepted result.
    always @(posedge clk)
    begin : channel_monitor
        word_result_t want;

        if (rst_n && req_ch.valid && req_ch.ready)
        begin
            if (walk_letter(req_ch.kind, req_ch.letter_code, req_ch.last_letter, want))
            begin
                if (typed_now)
                begin
                    want.count = typed_count;
                    want.full  = typed_full;
                end
                expected_words = {expected_words, want};
            end
        end

        if (rsp_ch.valid && rsp_ch.ready)
        begin
            if (expected_words.size() == 0)
            begin
                $error("result item with no expectation: word_count %0d, table_full %0d",
                       rsp_ch.word_count, rsp_ch.table_full);
                fail_count++;
            end
            else
            begin
                want = expected_words.pop_front();
                if (rsp_ch.word_count !== want.count)
                begin
                    $error("word_count mismatch: expected %0d, actual %0d",
                           want.count, rsp_ch.word_count);
                    fail_count++;
                end
                if (rsp_ch.table_full !== want.full)
                begin
                    $error("table_full mismatch: expected %0d, actual %0d",
                           want.full, rsp_ch.table_full);
                    fail_count++;
                end
            end
        end
    end

    // Result receiver: switches between always ready, coin flips, mostly stalled and periodic.
    initial
    begin
        int mode;
        int left;
        int tick;

        mode = 0;
        left = 0;
        tick = 0;
        rsp_ch.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (left == 0)
            begin
                mode = $urandom_range(0, 3);
                left = $urandom_range(50, 400);
            end
            left--;
            tick++;
            case (mode)
                0:       rsp_ch.ready <= 1'b1;
                1:       rsp_ch.ready <= 1'($urandom_range(0, 1));
                2:       rsp_ch.ready <= ($urandom_range(0, 3) == 0);
                default: rsp_ch.ready <= (tick % 5 == 0);
            endcase
        end
    end

    // Watchdog: ends the run after a long stretch with no item moving on either channel.
    initial
    begin
        int idle_cycles;

        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((req_ch.valid && req_ch.ready) || (rsp_ch.valid && rsp_ch.ready))
            begin
                idle_cycles = 0;
            end
            else
            begin
                idle_cycles++;
            end
        end
        $error("no item moved for %0d cycles", IDLE_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    function automatic void refresh_pool();
        foreach (letter_pool[i])
        begin
            letter_pool[i] = LETTER_W'($urandom_range(0, LETTERS - 1));
        end
    endfunction

    // Mostly letters from a small pool so that words repeat and share prefixes.
    function automatic logic [LETTER_W-1:0] pick_letter();
        if ($urandom_range(0, 9) < 7)
        begin
            return letter_pool[$urandom_range(0, 3)];
        end
        return LETTER_W'($urandom_range(0, 63));
    endfunction

    // Drives one item and waits for its handshake; ends a burst with a random gap unless no_gaps.
    task automatic send_item(input logic [KIND_W-1:0] kind, input logic [LETTER_W-1:0] code,
                             input logic last, input bit typed,
                             input logic [COUNT_W-1:0] tcount, input logic tfull);
        req_ch.valid       <= 1'b1;
        req_ch.kind        <= kind;
        req_ch.letter_code <= code;
        req_ch.last_letter <= last;
        typed_now          <= typed;
        typed_count        <= tcount;
        typed_full         <= tfull;
        @(posedge clk);
        while (!req_ch.ready)
        begin
            @(posedge clk);
        end
        if (kind != KIND_UNUSED)
        begin
            items_sent++;
        end
        burst_left--;
        if (burst_left <= 0 && !no_gaps)
        begin
            req_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 12)) @(posedge clk);
            burst_left = ($urandom_range(0, 9) < 7) ? $urandom_range(1, 30)
                                                    : $urandom_range(40, 200);
        end
    endtask

    task automatic send_letter(input logic [KIND_W-1:0] kind, input logic [LETTER_W-1:0] code,
                               input logic last);
        send_item(kind, code, last, 1'b0, '0, 1'b0);
    endtask

    task automatic send_word(input word_style_t style, input int len);
        logic [KIND_W-1:0] kind;

        for (int i = 0; i < len; i++)
        begin
            case (style)
                WORD_INSERT: kind = KIND_INSERT;
                WORD_SEARCH: kind = KIND_SEARCH;
                default:     kind = $urandom_range(0, 1) ? KIND_SEARCH : KIND_INSERT;
            endcase
            send_letter(kind, pick_letter(), i == len - 1);
        end
    endtask

    // Holds the input channel idle until every expected result has come back.
    task automatic drain();
        req_ch.valid <= 1'b0;
        do
        begin
            @(posedge clk);
        end
        while (expected_words.size() != 0);
    endtask

    // Mostly well-formed words; some abandoned words, ignored items and clears.
    task automatic run_random(input int quota);
        int stop_at;
        int pick;
        int len;

        stop_at = items_sent + quota;
        while (items_sent < stop_at)
        begin
            if ($urandom_range(0, 99) == 0)
            begin
                refresh_pool();
            end
            pick = $urandom_range(0, 99);
            len  = ($urandom_range(0, 9) == 0) ? $urandom_range(5, 14) : $urandom_range(1, 4);
            if (pick < 52)
            begin
                send_word(WORD_INSERT, len);
            end
            else if (pick < 82)
            begin
                send_word(WORD_SEARCH, len);
            end
            else if (pick < 92)
            begin
                send_word(WORD_MIXED, len);
            end
            else if (pick < 95)
            begin
                // A word cut off by a clear.
                for (int i = 0; i < len; i++)
                begin
                    send_letter($urandom_range(0, 1) ? KIND_SEARCH : KIND_INSERT,
                                pick_letter(), 1'b0);
                end
                send_letter(KIND_CLEAR, LETTER_W'($urandom_range(0, 63)),
                            1'($urandom_range(0, 1)));
            end
            else if (pick < 99)
            begin
                send_letter(KIND_UNUSED, LETTER_W'($urandom_range(0, 63)),
                            1'($urandom_range(0, 1)));
            end
            else
            begin
                send_letter(KIND_CLEAR, LETTER_W'($urandom_range(0, 63)),
                            1'($urandom_range(0, 1)));
            end
        end
    endtask

    initial
    begin
        stim_row_t directed_rows [25];

        //                kind         code   last  typed count   full
        directed_rows = '{
            '{KIND_SEARCH, 6'd0,  1'b1, 1'b1, 16'd0, 1'b0},  // empty table misses
            '{KIND_INSERT, 6'd0,  1'b1, 1'b1, 16'd1, 1'b0},
            '{KIND_INSERT, 6'd0,  1'b1, 1'b1, 16'd2, 1'b0},
            '{KIND_SEARCH, 6'd0,  1'b1, 1'b1, 16'd2, 1'b0},
            '{KIND_INSERT, 6'd51, 1'b0, 1'b0, 16'd0, 1'b0},
            '{KIND_INSERT, 6'd63, 1'b1, 1'b1, 16'd1, 1'b0},  // out of range folds to 51
            '{KIND_SEARCH, 6'd52, 1'b0, 1'b0, 16'd0, 1'b0},
            '{KIND_SEARCH, 6'd51, 1'b1, 1'b0, 16'd0, 1'b0},
            '{KIND_UNUSED, 6'd17, 1'b1, 1'b0, 16'd0, 1'b0},  // ignored, no result
            '{KIND_INSERT, 6'd0,  1'b0, 1'b0, 16'd0, 1'b0},
            '{KIND_SEARCH, 6'd5,  1'b1, 1'b1, 16'd0, 1'b0},  // mixed word, missing link
            '{KIND_SEARCH, 6'd7,  1'b0, 1'b0, 16'd0, 1'b0},
            '{KIND_INSERT, 6'd7,  1'b1, 1'b1, 16'd0, 1'b0},  // broken word, no insert
            '{KIND_SEARCH, 6'd7,  1'b1, 1'b1, 16'd0, 1'b0},
            '{KIND_INSERT, 6'd25, 1'b0, 1'b0, 16'd0, 1'b0},
            '{KIND_INSERT, 6'd26, 1'b0, 1'b0, 16'd0, 1'b0},
            '{KIND_CLEAR,  6'd0,  1'b1, 1'b0, 16'd0, 1'b0},  // clear drops the open word
            '{KIND_SEARCH, 6'd0,  1'b1, 1'b1, 16'd0, 1'b0},
            '{KIND_INSERT, 6'd0,  1'b1, 1'b1, 16'd1, 1'b0},
            '{KIND_INSERT, 6'd0,  1'b0, 1'b0, 16'd0, 1'b0},
            '{KIND_INSERT, 6'd1,  1'b1, 1'b0, 16'd0, 1'b0},
            '{KIND_SEARCH, 6'd0,  1'b0, 1'b0, 16'd0, 1'b0},
            '{KIND_INSERT, 6'd1,  1'b1, 1'b0, 16'd0, 1'b0},
            '{KIND_CLEAR,  6'd42, 1'b0, 1'b0, 16'd0, 1'b0},
            '{KIND_INSERT, 6'd0,  1'b1, 1'b1, 16'd1, 1'b0}
        };

        // Every input known from time zero; reset is held low, then released.
        rst_n              <= 1'b0;
        req_ch.valid       <= 1'b0;
        req_ch.kind        <= KIND_INSERT;
        req_ch.letter_code <= '0;
        req_ch.last_letter <= 1'b0;
        typed_now          <= 1'b0;
        typed_count        <= '0;
        typed_full         <= 1'b0;
        fail_count = 0;
        items_sent = 0;
        burst_left = 10;
        no_gaps    = 1'b0;
        wipe_trie();
        refresh_pool();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed table.
        foreach (directed_rows[i])
        begin
            send_item(directed_rows[i].kind, directed_rows[i].code, directed_rows[i].last,
                      directed_rows[i].typed, directed_rows[i].count, directed_rows[i].full);
        end
        drain();

        run_random(900);

        // One single-letter word inserted back to back on a fresh table, then read back.
        drain();
        send_letter(KIND_CLEAR, 6'd0, 1'b0);
        no_gaps = 1'b1;
        repeat (40) send_letter(KIND_INSERT, 6'd38, 1'b1);
        send_item(KIND_SEARCH, 6'd38, 1'b1, 1'b1, 16'd40, 1'b0);
        no_gaps = 1'b0;

        run_random(880);

        drain();
        repeat (20) @(posedge clk);
        if (fail_count == 0 && expected_words.size() == 0)
        begin
            $display("All tests passed");
        end
        else
        begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

`default_nettype wire
